>>> hdl/epa_pkg.sv
// Shared widths, codes and limits of the entry pool allocator.
`timescale 1ns / 1ps

package epa_pkg;

  // Number of entries in the pool; a power of two in the range 16 to 65536.
  localparam int POOL_ENTRIES = 4096;
  // Bits of an entry index, and of a link that can also hold the null value.
  localparam int IDX_W = $clog2(POOL_ENTRIES);
  localparam int LINK_W = IDX_W + 1;

  // Fixed field widths of the channels.
  localparam int ADDR_W = 12;
  localparam int COUNT_W = 13;
  localparam int ALIGN_W = 4;
  localparam int OFFSET_W = 24;
  localparam int ESL_W = 4;

  // Gap arithmetic covers every alignment that ALIGN_W can express.
  localparam int GAP_W = 2 ** ALIGN_W;

  // Reset value of the entry size register.
  localparam logic [ESL_W-1:0] ESL_RESET = ESL_W'(4);

  // The null link marks the end of either list.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    OP_ADD_CHUNK   = 2'd0,
    OP_ALLOC_ONE   = 2'd1,
    OP_FREE        = 2'd2,
    OP_ALLOC_CONTIG = 2'd3
  } opcode_t;

endpackage

>>> hdl/epa_ifs.sv
// Channel interfaces of the entry pool allocator: requests, results and configuration.
`timescale 1ns / 1ps

interface epa_req_if;
  logic                         valid;
  logic                         ready;
  epa_pkg::opcode_t             opcode;
  logic [epa_pkg::ADDR_W-1:0]   entry_address;
  logic [epa_pkg::COUNT_W-1:0]  entry_count;
  logic [epa_pkg::ALIGN_W-1:0]  align_log2;

  modport source (output valid, opcode, entry_address, entry_count, align_log2,
                  input ready);
  modport sink (input valid, opcode, entry_address, entry_count, align_log2,
                output ready);
endinterface

interface epa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic [epa_pkg::ADDR_W-1:0]    result_entry;
  logic [epa_pkg::OFFSET_W-1:0]  result_byte_offset;

  modport source (output valid, success, result_entry, result_byte_offset,
                  input ready);
  modport sink (input valid, success, result_entry, result_byte_offset,
                output ready);
endinterface

interface epa_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [epa_pkg::ESL_W-1:0]   wdata;

  modport source (output valid, wdata, input ready);
  modport sink (input valid, wdata, output ready);
endinterface

>>> hdl/entry_pool_allocator_top.sv
// Top level of the entry pool allocator: sequencer, link and size memories, result register.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+---------------------------------------------------
//   req     | in  | valid/ready       | opcode, entry_address, entry_count, align_log2
//   rsp     | out | valid/ready       | success, result_entry, result_byte_offset
//   cfg     | in  | valid/ready       | wdata (entry_size_log2), always ready
//
// One request is in flight at a time; each memory has one read and one write port.
// Add and free take the execute step only; a single allocation adds an evaluate step unless it fails.
// A contiguous allocation reads and evaluates each chunk visited, then splits, keeps a gap and relinks.
// Reset empties both lists and loads the entry size; the memories need no clearing.
// A new result waits in its last step while rsp still holds an unaccepted one,
// and no request is taken meanwhile.
`timescale 1ns / 1ps

module entry_pool_allocator_top (
  input  logic             clk,
  input  logic             rst,
  epa_req_if.sink          req,
  epa_rsp_if.source        rsp,
  epa_cfg_if.sink          cfg
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_A1_EVAL = 9'b000000100,
    S_C_READ  = 9'b000001000,
    S_C_EVAL  = 9'b000010000,
    S_C_SPLIT = 9'b000100000,
    S_C_GAP   = 9'b001000000,
    S_C_LINK  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state;

  // Architectural state.
  logic [epa_pkg::ESL_W-1:0] entry_size_log2;
  epa_pkg::link_t free_head;
  epa_pkg::link_t chunk_head;

  // Request registers.
  epa_pkg::opcode_t op_r;
  epa_pkg::idx_t addr_r;
  epa_pkg::count_t count_r;
  logic [epa_pkg::ALIGN_W-1:0] alog_r;

  // Walk registers.
  epa_pkg::link_t cur;
  epa_pkg::link_t prev;
  epa_pkg::link_t steps;
  epa_pkg::link_t tail_r;
  epa_pkg::link_t nxt_r;
  epa_pkg::idx_t nc_r;
  epa_pkg::count_t rem_r;
  logic [epa_pkg::GAP_W-1:0] before_r;

  // Outcome registers.
  logic ok_r;
  logic has_r;
  epa_pkg::idx_t where_r;

  // Memories and their ports.
  epa_pkg::link_t link_mem [epa_pkg::POOL_ENTRIES];
  epa_pkg::count_t size_mem [epa_pkg::POOL_ENTRIES];
  epa_pkg::link_t link_rd;
  epa_pkg::count_t size_rd;
  logic rd_en;
  epa_pkg::idx_t rd_addr;
  logic link_we;
  epa_pkg::idx_t link_wa;
  epa_pkg::link_t link_wd;
  logic size_we;
  epa_pkg::idx_t size_wa;
  epa_pkg::count_t size_wd;

  // Decoded conditions.
  logic free_valid;
  logic chunk_valid;
  logic cur_valid;
  logic prev_valid;
  logic walk_go;
  epa_pkg::idx_t cur_idx;
  epa_pkg::idx_t chunk_idx;
  epa_pkg::idx_t split_idx;

  // Gap and fit unit used once per visited chunk.
  logic [epa_pkg::GAP_W-1:0] align_mask;
  logic [epa_pkg::GAP_W-1:0] gap;
  logic [epa_pkg::GAP_W:0] need;
  logic fits;
  logic fits_exact;
  epa_pkg::idx_t start;
  epa_pkg::idx_t nc;

  assign free_valid  = free_head < epa_pkg::NULL_LINK;
  assign chunk_valid = chunk_head < epa_pkg::NULL_LINK;
  assign cur_valid   = cur < epa_pkg::NULL_LINK;
  assign prev_valid  = prev < epa_pkg::NULL_LINK;
  assign walk_go     = cur_valid && (steps < epa_pkg::NULL_LINK);
  assign cur_idx     = cur[epa_pkg::IDX_W-1:0];
  assign chunk_idx   = chunk_head[epa_pkg::IDX_W-1:0];
  assign split_idx   = chunk_idx + epa_pkg::IDX_W'(1);

  assign align_mask = (epa_pkg::GAP_W'(1) << alog_r) - epa_pkg::GAP_W'(1);
  assign gap        = (epa_pkg::GAP_W'(0) - epa_pkg::GAP_W'(cur_idx)) & align_mask;
  assign need       = (epa_pkg::GAP_W + 1)'(gap) + (epa_pkg::GAP_W + 1)'(count_r);
  assign fits       = need <= (epa_pkg::GAP_W + 1)'(size_rd);
  assign fits_exact = need == (epa_pkg::GAP_W + 1)'(size_rd);
  assign start      = cur_idx + epa_pkg::IDX_W'(gap);
  assign nc         = start + epa_pkg::IDX_W'(count_r);

  // Configuration register; always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_size_log2 <= epa_pkg::ESL_RESET;
    end else if (cfg.valid) begin
      entry_size_log2 <= cfg.wdata;
    end
  end

  assign req.ready = (state == S_IDLE);

  // Memory port control for each sequencer step.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_idx;
    link_we = 1'b0;
    link_wa = addr_r;
    link_wd = chunk_head;
    size_we = 1'b0;
    size_wa = addr_r;
    size_wd = count_r;
    unique case (state)
      S_EXEC: begin
        unique case (op_r)
          epa_pkg::OP_ADD_CHUNK: begin
            link_we = (count_r != '0);
            size_we = (count_r != '0);
          end
          epa_pkg::OP_FREE: begin
            link_we = 1'b1;
            link_wd = free_head;
          end
          epa_pkg::OP_ALLOC_ONE: begin
            rd_en   = free_valid || chunk_valid;
            rd_addr = free_valid ? free_head[epa_pkg::IDX_W-1:0] : chunk_idx;
          end
          epa_pkg::OP_ALLOC_CONTIG: begin
            rd_en = 1'b0;
          end
        endcase
      end
      S_A1_EVAL: begin
        // Split one entry off the head chunk: the remainder starts one entry later.
        if (!free_valid && (size_rd > epa_pkg::COUNT_W'(1))) begin
          link_we = 1'b1;
          link_wa = split_idx;
          link_wd = link_rd;
          size_we = 1'b1;
          size_wa = split_idx;
          size_wd = size_rd - epa_pkg::COUNT_W'(1);
        end
      end
      S_C_READ: begin
        rd_en   = walk_go;
        rd_addr = cur_idx;
      end
      S_C_SPLIT: begin
        link_we = 1'b1;
        link_wa = nc_r;
        link_wd = nxt_r;
        size_we = 1'b1;
        size_wa = nc_r;
        size_wd = rem_r;
      end
      S_C_GAP: begin
        // The leading gap stays a chunk that points at what follows the allocation.
        link_we = 1'b1;
        link_wa = cur_idx;
        link_wd = tail_r;
        size_we = 1'b1;
        size_wa = cur_idx;
        size_wd = epa_pkg::COUNT_W'(before_r);
      end
      S_C_LINK: begin
        link_we = prev_valid;
        link_wa = prev[epa_pkg::IDX_W-1:0];
        link_wd = (before_r != '0) ? cur : tail_r;
      end
      S_IDLE, S_C_EVAL, S_DONE: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Link and size memories with registered reads.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (rd_en) begin
      link_rd <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (rd_en) begin
      size_rd <= size_mem[rd_addr];
    end
  end

  // Sequencer and list heads.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= epa_pkg::NULL_LINK;
      chunk_head <= epa_pkg::NULL_LINK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r    <= req.opcode;
            addr_r  <= epa_pkg::IDX_W'(req.entry_address);
            count_r <= req.entry_count;
            alog_r  <= req.align_log2;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          ok_r  <= 1'b0;
          has_r <= 1'b0;
          unique case (op_r)
            epa_pkg::OP_ADD_CHUNK: begin
              if (count_r != '0) begin
                chunk_head <= epa_pkg::LINK_W'(addr_r);
                ok_r       <= 1'b1;
              end
              state <= S_DONE;
            end
            epa_pkg::OP_FREE: begin
              free_head <= epa_pkg::LINK_W'(addr_r);
              ok_r      <= 1'b1;
              state     <= S_DONE;
            end
            epa_pkg::OP_ALLOC_ONE: begin
              state <= (free_valid || chunk_valid) ? S_A1_EVAL : S_DONE;
            end
            epa_pkg::OP_ALLOC_CONTIG: begin
              cur   <= chunk_head;
              prev  <= epa_pkg::NULL_LINK;
              steps <= '0;
              state <= S_C_READ;
            end
          endcase
        end
        S_A1_EVAL: begin
          ok_r  <= 1'b1;
          has_r <= 1'b1;
          if (free_valid) begin
            where_r   <= free_head[epa_pkg::IDX_W-1:0];
            free_head <= link_rd;
          end else begin
            where_r <= chunk_idx;
            if (size_rd > epa_pkg::COUNT_W'(1)) begin
              chunk_head <= epa_pkg::LINK_W'(split_idx);
            end else begin
              chunk_head <= link_rd;
            end
          end
          state <= S_DONE;
        end
        S_C_READ: begin
          if (walk_go) begin
            steps <= steps + epa_pkg::LINK_W'(1);
            state <= S_C_EVAL;
          end else begin
            state <= S_DONE;
          end
        end
        S_C_EVAL: begin
          if (fits) begin
            ok_r     <= 1'b1;
            has_r    <= 1'b1;
            where_r  <= start;
            nxt_r    <= link_rd;
            nc_r     <= nc;
            rem_r    <= epa_pkg::COUNT_W'((epa_pkg::GAP_W + 1)'(size_rd) - need);
            before_r <= gap;
            tail_r   <= fits_exact ? link_rd : epa_pkg::LINK_W'(nc);
            if (!fits_exact) begin
              state <= S_C_SPLIT;
            end else if (gap != '0) begin
              state <= S_C_GAP;
            end else begin
              state <= S_C_LINK;
            end
          end else begin
            prev  <= cur;
            cur   <= link_rd;
            state <= S_C_READ;
          end
        end
        S_C_SPLIT: begin
          state <= (before_r != '0) ? S_C_GAP : S_C_LINK;
        end
        S_C_GAP: begin
          state <= S_C_LINK;
        end
        S_C_LINK: begin
          // The link that pointed at the visited chunk now points at the leading gap, or else past the allocation.
          if (!prev_valid) begin
            chunk_head <= (before_r != '0) ? cur : tail_r;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register; it holds until the transfer on rsp.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_DONE) && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!rsp.valid || rsp.ready)) begin
      rsp.success <= ok_r;
      if (has_r) begin
        rsp.result_entry       <= epa_pkg::ADDR_W'(where_r);
        rsp.result_byte_offset <= epa_pkg::OFFSET_W'(where_r) << entry_size_log2;
      end else begin
        rsp.result_entry       <= '0;
        rsp.result_byte_offset <= '0;
      end
    end
  end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the entry pool allocator top level.
`timescale 1ns / 1ps

module testbench;
  import epa_pkg::*;

  // One expected result of an allocator request.
  typedef struct packed {
    logic                success;
    logic [ADDR_W-1:0]   entry;
    logic [OFFSET_W-1:0] byte_offset;
  } alloc_result_t;

  // Who owns an entry, as far as the stimulus knows.
  typedef enum bit [1:0] {
    ENT_OUTSIDE = 2'd0,
    ENT_POOLED  = 2'd1,
    ENT_HELD    = 2'd2
  } entry_use_t;

  localparam int unsigned NIL = POOL_ENTRIES;
  localparam int unsigned SIZE_MASK = (1 << COUNT_W) - 1;
  localparam int unsigned POOLED_LIMIT = 1400;

  logic clk;
  logic rst;

  epa_req_if req_ch ();
  epa_rsp_if rsp_ch ();
  epa_cfg_if cfg_ch ();

  entry_pool_allocator_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Mirror of the allocator state.
  int unsigned          free_head = NIL;
  int unsigned          chunk_head = NIL;
  int unsigned          link_mem [POOL_ENTRIES];
  int unsigned          size_mem [POOL_ENTRIES];
  logic [ESL_W-1:0]     entry_size_model = ESL_RESET;

  alloc_result_t        alloc_results_due[$];
  int                   error_count = 0;

  // Traffic shaping knobs of the sender and the receiver.
  int                   send_idle_pct = 0;
  int                   rsp_stall_pct = 0;
  int                   rsp_hold_cycles = 0;

  // Ownership map that keeps the random stimulus free of overlaps.
  entry_use_t           entry_use [POOL_ENTRIES];
  int unsigned          pooled_count = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #(64'd60_000_000 * 12);
    $display("** entry_pool_allocator_top: FAILED **");
    $finish;
  end

  // Writes the link that points at the current chunk: the list head or the previous chunk.
  function automatic void relink(input int unsigned prev, input int unsigned v);
    if (prev < POOL_ENTRIES) begin
      link_mem[prev] = v;
    end else begin
      chunk_head = v;
    end
  endfunction

  // Applies one request to the mirror and returns the result the block must give.
  function automatic alloc_result_t predict_allocation(input opcode_t op,
                                                       input logic [ADDR_W-1:0] addr_in,
                                                       input logic [COUNT_W-1:0] count_in,
                                                       input logic [ALIGN_W-1:0] alog_in);
    alloc_result_t r;
    int unsigned addr, count, where, prev, cur, steps, align, gap, csize, need;
    int unsigned nxt, start, nc, here;
    bit ok, has_entry, found;
    addr = addr_in % POOL_ENTRIES;
    count = count_in;
    ok = 1'b0;
    has_entry = 1'b0;
    where = 0;
    case (op)
      OP_ADD_CHUNK: begin
        // A chunk of size zero is refused.
        if (count != 0) begin
          size_mem[addr] = count;
          link_mem[addr] = chunk_head;
          chunk_head = addr;
          ok = 1'b1;
        end
      end
      OP_ALLOC_ONE: begin
        // The free list goes first; otherwise the head chunk gives its first entry.
        if (free_head < POOL_ENTRIES) begin
          where = free_head;
          free_head = link_mem[free_head];
          ok = 1'b1;
        end else if (chunk_head < POOL_ENTRIES) begin
          where = chunk_head;
          if (size_mem[where] <= 1) begin
            chunk_head = link_mem[where];
          end else begin
            nc = (where + 1) % POOL_ENTRIES;
            link_mem[nc] = link_mem[where];
            size_mem[nc] = (size_mem[where] - 1) & SIZE_MASK;
            chunk_head = nc;
          end
          ok = 1'b1;
        end
        has_entry = ok;
      end
      OP_FREE: begin
        link_mem[addr] = free_head;
        free_head = addr;
        ok = 1'b1;
      end
      default: begin
        // First-fit walk, bounded by the pool size so that a cyclic list ends.
        align = 32'd1 << alog_in;
        prev = NIL;
        cur = chunk_head;
        steps = 0;
        found = 1'b0;
        while (!found && cur < POOL_ENTRIES && steps < POOL_ENTRIES) begin
          gap = (align - (cur & (align - 1))) & (align - 1);
          csize = size_mem[cur];
          need = gap + count;
          steps++;
          if (need <= csize) begin
            nxt = link_mem[cur];
            start = (cur + gap) % POOL_ENTRIES;
            if (need == csize) begin
              relink(prev, nxt);
            end else begin
              nc = (start + count) % POOL_ENTRIES;
              size_mem[nc] = (csize - need) & SIZE_MASK;
              link_mem[nc] = nxt;
              relink(prev, nc);
            end
            // The leading gap stays a chunk in the same list position.
            if (gap >= 1) begin
              here = (prev < POOL_ENTRIES) ? link_mem[prev] : chunk_head;
              link_mem[cur] = here;
              relink(prev, cur);
              size_mem[cur] = gap & SIZE_MASK;
            end
            where = start;
            found = 1'b1;
          end else begin
            prev = cur;
            cur = link_mem[cur];
          end
        end
        ok = found;
        has_entry = found;
      end
    endcase
    r.success = ok;
    r.entry = has_entry ? ADDR_W'(where) : '0;
    r.byte_offset = has_entry ? OFFSET_W'(where << entry_size_model) : '0;
    return r;
  endfunction

  // Records who owns a run of entries after a request.
  function automatic void mark_range(input int unsigned first, input int unsigned n,
                                     input entry_use_t use_as);
    int unsigned idx;
    for (int unsigned i = 0; i < n; i++) begin
      idx = (first + i) % POOL_ENTRIES;
      if (entry_use[idx] == ENT_POOLED) pooled_count--;
      if (use_as == ENT_POOLED) pooled_count++;
      entry_use[idx] = use_as;
    end
  endfunction

  // Offers one request, waits for its transfer and records the expected result.
  task automatic send_request(input opcode_t op, input logic [ADDR_W-1:0] addr,
                              input logic [COUNT_W-1:0] count,
                              input logic [ALIGN_W-1:0] alog);
    alloc_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.entry_address <= addr;
    req_ch.entry_count   <= count;
    req_ch.align_log2    <= alog;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    want = predict_allocation(op, addr, count, alog);
    alloc_results_due.push_back(want);
    case (op)
      OP_ADD_CHUNK:  if (want.success) mark_range(addr, count, ENT_POOLED);
      OP_FREE:       mark_range(addr, 1, ENT_POOLED);
      OP_ALLOC_ONE:  if (want.success) mark_range(want.entry, 1, ENT_HELD);
      default:       if (want.success) mark_range(want.entry, count, ENT_HELD);
    endcase
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (alloc_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the entry size register; the block must be idle.
  task automatic write_entry_size(input logic [ESL_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.wdata <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    entry_size_model = v;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Picks one request: mostly a well-formed pool user, with some noise.
  task automatic send_random_request();
    int unsigned pick, first, n, tries, k;
    bit clear;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // Noise that cannot corrupt the lists: odd sizes and alignments, refused adds.
      case ($urandom_range(2))
        0: send_request(OP_ALLOC_CONTIG, ADDR_W'($urandom_range(4095)),
                        COUNT_W'($urandom_range(SIZE_MASK)), ALIGN_W'($urandom_range(15)));
        1: send_request(OP_ADD_CHUNK, ADDR_W'($urandom_range(4095)), '0,
                        ALIGN_W'($urandom_range(15)));
        default: send_request(OP_ALLOC_ONE, ADDR_W'($urandom_range(4095)),
                              COUNT_W'($urandom_range(SIZE_MASK)),
                              ALIGN_W'($urandom_range(15)));
      endcase
    end else if (pick < 28 && pooled_count < POOLED_LIMIT) begin
      // Add a chunk over entries that the pool does not own yet.
      n = ($urandom_range(9) == 0) ? $urandom_range(256, 1) : $urandom_range(48, 1);
      clear = 1'b0;
      for (tries = 0; tries < 8 && !clear; tries++) begin
        first = $urandom_range(4095);
        clear = 1'b1;
        for (k = 0; k < n; k++) begin
          if (entry_use[(first + k) % POOL_ENTRIES] == ENT_POOLED) clear = 1'b0;
        end
      end
      if (clear) begin
        send_request(OP_ADD_CHUNK, ADDR_W'(first), COUNT_W'(n), ALIGN_W'($urandom_range(15)));
      end else begin
        send_request(OP_ALLOC_ONE, ADDR_W'($urandom_range(4095)), '0, '0);
      end
    end else if (pick < 53) begin
      // Give back an entry that was handed out earlier.
      clear = 1'b0;
      for (tries = 0; tries < 32 && !clear; tries++) begin
        first = $urandom_range(4095);
        clear = (entry_use[first] == ENT_HELD);
      end
      if (clear) begin
        send_request(OP_FREE, ADDR_W'(first), COUNT_W'($urandom_range(SIZE_MASK)),
                     ALIGN_W'($urandom_range(15)));
      end else begin
        send_request(OP_ALLOC_ONE, ADDR_W'($urandom_range(4095)), '0, '0);
      end
    end else if (pick < 73) begin
      send_request(OP_ALLOC_ONE, ADDR_W'($urandom_range(4095)),
                   COUNT_W'($urandom_range(SIZE_MASK)), ALIGN_W'($urandom_range(15)));
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
      k = ($urandom_range(9) == 0) ? $urandom_range(15, 7) : $urandom_range(5);
      send_request(OP_ALLOC_CONTIG, ADDR_W'($urandom_range(4095)), COUNT_W'(n), ALIGN_W'(k));
    end
  endtask

  // Empty pool: allocation fails and a zero-size chunk is refused.
  task automatic test_empty_pool();
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    send_request(OP_ADD_CHUNK, ADDR_W'(5), '0, '0);
    wait_drain();
  endtask

  // Single allocation splits the head chunk, with addresses wrapping at the pool end.
  task automatic test_split_and_wrap();
    send_request(OP_ADD_CHUNK, ADDR_W'(4095), COUNT_W'(4), '0);
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    // A contiguous count of zero succeeds and consumes nothing.
    send_request(OP_ALLOC_CONTIG, '0, '0, '0);
    send_request(OP_ALLOC_CONTIG, '0, COUNT_W'(2), '0);
    wait_drain();
  endtask

  // Aligned first fit: leading gaps, remainders, exact fits and large alignment.
  task automatic test_contiguous_align();
    send_request(OP_ADD_CHUNK, ADDR_W'(100), COUNT_W'(50), '0);
    send_request(OP_ALLOC_CONTIG, '0, COUNT_W'(8), ALIGN_W'(3));
    send_request(OP_ALLOC_CONTIG, '0, COUNT_W'(16), ALIGN_W'(4));
    send_request(OP_ALLOC_CONTIG, '0, COUNT_W'(22), ALIGN_W'(5));
    send_request(OP_ALLOC_CONTIG, '0, COUNT_W'(4), ALIGN_W'(15));
    send_request(OP_ALLOC_CONTIG, '0, COUNT_W'(4), ALIGN_W'(2));
    wait_drain();
  endtask

  // Double free makes a looping free list; an add over the entry breaks the loop.
  task automatic test_double_free();
    send_request(OP_FREE, ADDR_W'(7), '0, '0);
    send_request(OP_FREE, ADDR_W'(7), '0, '0);
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    send_request(OP_ADD_CHUNK, ADDR_W'(7), COUNT_W'(1), '0);
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    wait_drain();
  endtask

  // A chunk added twice links to itself; the walk gives up, then a free repairs it.
  task automatic test_cyclic_chunk_list();
    send_request(OP_ADD_CHUNK, ADDR_W'(9), COUNT_W'(1), '0);
    send_request(OP_ADD_CHUNK, ADDR_W'(9), COUNT_W'(1), '0);
    send_request(OP_ALLOC_CONTIG, '0, COUNT_W'(2), '0);
    send_request(OP_FREE, ADDR_W'(9), '0, '0);
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    send_request(OP_ALLOC_ONE, '0, '0, '0);
    wait_drain();
  endtask

  // Random pool traffic under each idling pattern and entry size.
  task automatic test_random_traffic();
    int idle_pct [4] = '{0, 79, 0, 23};
    int stall_pct [4] = '{0, 0, 79, 23};
    logic [ESL_W-1:0] sizes [4] = '{ESL_W'(3), ESL_W'(12), ESL_W'(15), ESL_W'(0)};
    for (int p = 0; p < 4; p++) begin
      write_entry_size(sizes[p]);
      send_idle_pct = idle_pct[p];
      rsp_stall_pct = stall_pct[p];
      repeat (460) send_random_request();
      wait_drain();
    end
  endtask

  // Long receiver hold-off fills the block; the sender then pauses until all is back.
  task automatic test_backpressure();
    write_entry_size(ESL_W'($urandom_range(12, 3)));
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    rsp_hold_cycles = 300;
    repeat (40) send_random_request();
    wait_drain();
    send_idle_pct = 10;
    rsp_stall_pct = 50;
    rsp_hold_cycles = 150;
    repeat (60) send_random_request();
    wait_drain();
    rsp_stall_pct = 0;
    send_idle_pct = 0;
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold_cycles--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (alloc_results_due.size() == 0) begin
        $display("%0t: unexpected result: success=%0d entry=%0d offset=%0d", $time,
                 rsp_ch.success, rsp_ch.result_entry, rsp_ch.result_byte_offset);
        error_count++;
      end else begin
        want = alloc_results_due.pop_front();
        if (rsp_ch.success !== want.success) begin
          $display("%0t: success mismatch: expected %0d, actual %0d", $time,
                   want.success, rsp_ch.success);
          error_count++;
        end
        if (rsp_ch.result_entry !== want.entry) begin
          $display("%0t: result_entry mismatch: expected %0d, actual %0d", $time,
                   want.entry, rsp_ch.result_entry);
          error_count++;
        end
        if (rsp_ch.result_byte_offset !== want.byte_offset) begin
          $display("%0t: result_byte_offset mismatch: expected 0x%06h, actual 0x%06h",
                   $time, want.byte_offset, rsp_ch.result_byte_offset);
          error_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_ADD_CHUNK;
    req_ch.entry_address <= '0;
    req_ch.entry_count   <= '0;
    req_ch.align_log2    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.wdata         <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pool();
    test_split_and_wrap();
    test_contiguous_align();
    test_double_free();
    test_cyclic_chunk_list();
    test_random_traffic();
    test_backpressure();

    wait_drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && alloc_results_due.size() == 0) begin
      $display("** entry_pool_allocator_top: PASSED **");
    end else begin
      $display("** entry_pool_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> entry_pool_allocator_top.f
hdl/epa_pkg.sv
hdl/epa_ifs.sv
hdl/entry_pool_allocator_top.sv
dv/testbench.sv
